/* src/sfr_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// sfr_pkg
// Shared constants and types for the sync frame receiver with XOR check.
// ----------------------------------------------------------------------------
package sfr_pkg;

    localparam int PAYLOAD_LEN = 1025;
    localparam int POS_W       = $clog2(PAYLOAD_LEN + 1);
    localparam int ADDR_W      = $clog2(PAYLOAD_LEN);
    localparam int IDX_W       = 11;
    localparam int BYTE_W      = 8;

    localparam logic [BYTE_W-1:0] SYNC_FIRST  = 8'hAA;
    localparam logic [BYTE_W-1:0] SYNC_SECOND = 8'h55;

    localparam logic KIND_RX   = 1'b0;
    localparam logic KIND_READ = 1'b1;

    typedef struct packed {
        logic              en;
        logic [ADDR_W-1:0] addr;
        logic [BYTE_W-1:0] data;
    } wr_req_t;

    typedef struct packed {
        logic              frame_done;
        logic              frame_good;
        logic [BYTE_W-1:0] read_data;
        logic              frame_valid;
    } out_item_t;

endpackage
`default_nettype wire

/* src/sfr_parser.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// sfr_parser
// Sync hunt, payload write position, running XOR and frame verdict.
// ----------------------------------------------------------------------------
module sfr_parser
    import sfr_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              take,
    input  wire logic [BYTE_W-1:0] rx_byte,
    output wr_req_t                wr,
    output logic                   done,
    output logic                   good,
    output logic                   flag_next
);

    localparam logic [1:0] PH_HUNT1 = 2'd0;
    localparam logic [1:0] PH_HUNT2 = 2'd1;
    localparam logic [1:0] PH_DATA  = 2'd2;
    localparam logic [1:0] PH_CHECK = 2'd3;

    logic [1:0]        phase_reg;
    logic [1:0]        phase_next;
    logic [POS_W-1:0]  pos_reg;
    logic [POS_W-1:0]  pos_next;
    logic [BYTE_W-1:0] xor_reg;
    logic [BYTE_W-1:0] xor_next;
    logic              flag_reg;

    always_comb
    begin
        phase_next = phase_reg;
        pos_next   = pos_reg;
        xor_next   = xor_reg;
        flag_next  = flag_reg;
        done       = 1'b0;
        good       = 1'b0;
        wr.en      = 1'b0;
        wr.addr    = pos_reg[ADDR_W-1:0];
        wr.data    = rx_byte;
        if (take)
        begin
            case (phase_reg)
                PH_HUNT1:
                begin
                    if (rx_byte == SYNC_FIRST)
                    begin
                        phase_next = PH_HUNT2;
                    end
                end
                PH_HUNT2:
                begin
                    if (rx_byte == SYNC_SECOND)
                    begin
                        phase_next = PH_DATA;
                        pos_next   = '0;
                        xor_next   = '0;
                        flag_next  = 1'b0;
                    end
                    else if (rx_byte != SYNC_FIRST)
                    begin
                        phase_next = PH_HUNT1;
                    end
                end
                PH_DATA:
                begin
                    wr.en    = 1'b1;
                    xor_next = xor_reg ^ rx_byte;
                    pos_next = pos_reg + POS_W'(1);
                    if (pos_next >= POS_W'(PAYLOAD_LEN))
                    begin
                        phase_next = PH_CHECK;
                    end
                end
                default:
                begin
                    done = 1'b1;
                    if (xor_reg == rx_byte)
                    begin
                        good      = 1'b1;
                        flag_next = 1'b1;
                    end
                    phase_next = PH_HUNT1;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_HUNT1;
            pos_reg   <= '0;
            xor_reg   <= '0;
            flag_reg  <= 1'b0;
        end
        else
        begin
            phase_reg <= phase_next;
            pos_reg   <= pos_next;
            xor_reg   <= xor_next;
            flag_reg  <= flag_next;
        end
    end

    a_good_needs_done: assert property (@(posedge clk) disable iff (!rst_n)
        good |-> done)
        else $error("verdict good without frame end");

    a_pos_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_DATA) |-> (pos_reg < POS_W'(PAYLOAD_LEN)))
        else $error("write position beyond payload in data phase");

    a_flag_from_check: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(flag_reg) |-> ($past(phase_reg) == PH_CHECK))
        else $error("frame flag set outside checksum phase");

    a_done_returns_hunt: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> (phase_reg == PH_HUNT1))
        else $error("parser did not return to hunt after frame end");

endmodule
`default_nettype wire

/* src/sfr_store.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// sfr_store
// Payload byte memory: one write port, one registered read port.
// ----------------------------------------------------------------------------
module sfr_store
    import sfr_pkg::*;
(
    input  wire logic              clk,
    input  wire wr_req_t           wr,
    input  wire logic              rd_en,
    input  wire logic [ADDR_W-1:0] rd_addr,
    output logic [BYTE_W-1:0]      rd_data
);

    logic [BYTE_W-1:0] mem [0:PAYLOAD_LEN-1];
    logic [BYTE_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem[wr.addr] <= wr.data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule
`default_nettype wire

/* src/sfr_outq.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// sfr_outq
// Three-entry result queue; its head drives the result channel.
// ----------------------------------------------------------------------------
module sfr_outq
    import sfr_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      push,
    input  wire out_item_t push_item,
    output logic [1:0]     count,
    output logic           head_valid,
    output out_item_t      head_item,
    input  wire logic      head_stall
);

    localparam logic [1:0] DEPTH    = 2'd3;
    localparam logic [1:0] LAST_PTR = 2'd2;

    out_item_t  entry_reg [0:2];
    logic [1:0] wr_ptr_reg;
    logic [1:0] rd_ptr_reg;
    logic [1:0] count_reg;
    logic [1:0] count_next;
    logic       pop;

    assign head_valid = (count_reg != 2'd0);
    assign head_item  = entry_reg[rd_ptr_reg];
    assign pop        = head_valid && !head_stall;
    assign count      = count_reg;

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == LAST_PTR) ? 2'd0 : wr_ptr_reg + 2'd1;
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == LAST_PTR) ? 2'd0 : rd_ptr_reg + 2'd1;
            end
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == DEPTH) |-> !push || pop)
        else $error("result queue overflow");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= DEPTH)
        else $error("result queue count out of range");

endmodule
`default_nettype wire

/* src/sync_frame_receiver_xor_check.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// sync_frame_receiver_xor_check
// Sync pair framing receiver with XOR checksum and stored payload readback.
//
//  channel  | handshake              | payload
//  ---------+------------------------+-------------------------------------
//  request  | req_valid / req_stall  | kind, rx_byte, read_index
//  response | rsp_valid / rsp_stall  | frame_done, frame_good, read_data,
//           |                        | frame_valid
//
// One request is taken every cycle while req_stall is low; its response
// passes through the stage holding the registered memory read, then the result queue.
// req_stall comes from registers only: it rises when the result queue and the
// stage in front of it together hold three responses.
// Reset clears the parser and the queue; the payload memory is not cleared.
// ----------------------------------------------------------------------------
module sync_frame_receiver_xor_check
    import sfr_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              req_valid,
    output logic                   req_stall,
    input  wire logic              kind,
    input  wire logic [BYTE_W-1:0] rx_byte,
    input  wire logic [IDX_W-1:0]  read_index,
    output logic                   rsp_valid,
    input  wire logic              rsp_stall,
    output logic                   frame_done,
    output logic                   frame_good,
    output logic [BYTE_W-1:0]      read_data,
    output logic                   frame_valid
);

    localparam logic [2:0] QUEUE_ROOM = 3'd3;

    logic              accept;
    logic              take;
    logic              rd_en;
    logic              in_range;
    wr_req_t           wr;
    logic              done;
    logic              good;
    logic              flag_next;
    logic [BYTE_W-1:0] mem_data;

    logic              s1_valid_reg;
    logic              s1_done_reg;
    logic              s1_good_reg;
    logic              s1_flag_reg;
    logic              s1_read_reg;

    out_item_t         push_item;
    out_item_t         head_item;
    logic [1:0]        q_count;

    assign accept   = req_valid && !req_stall;
    assign take     = accept && (kind == KIND_RX);
    assign in_range = (read_index < IDX_W'(PAYLOAD_LEN));
    assign rd_en    = accept && (kind == KIND_READ) && in_range;

    assign req_stall = ({1'b0, q_count} + {2'b00, s1_valid_reg}) >= QUEUE_ROOM;

    sfr_parser u_parser (
        .clk       (clk),
        .rst_n     (rst_n),
        .take      (take),
        .rx_byte   (rx_byte),
        .wr        (wr),
        .done      (done),
        .good      (good),
        .flag_next (flag_next)
    );

    sfr_store u_store (
        .clk     (clk),
        .wr      (wr),
        .rd_en   (rd_en),
        .rd_addr (read_index[ADDR_W-1:0]),
        .rd_data (mem_data)
    );

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_done_reg <= done;
            s1_good_reg <= good;
            s1_flag_reg <= flag_next;
            s1_read_reg <= rd_en;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= accept;
        end
    end

    always_comb
    begin
        push_item.frame_done  = s1_done_reg;
        push_item.frame_good  = s1_good_reg;
        push_item.read_data   = s1_read_reg ? mem_data : '0;
        push_item.frame_valid = s1_flag_reg;
    end

    sfr_outq u_outq (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (s1_valid_reg),
        .push_item  (push_item),
        .count      (q_count),
        .head_valid (rsp_valid),
        .head_item  (head_item),
        .head_stall (rsp_stall)
    );

    assign frame_done  = head_item.frame_done;
    assign frame_good  = head_item.frame_good;
    assign read_data   = head_item.read_data;
    assign frame_valid = head_item.frame_valid;

endmodule
`default_nettype wire

/* tb/sync_frame_receiver_xor_check_checker.sv */
// ----------------------------------------------------------------------------
// sync_frame_receiver_xor_check_checker
// Watches both channels of the sync frame receiver. It tracks the parser, the
// running XOR, the payload copy and the verified flag for every accepted
// request. Each accepted response is compared in order with the response the
// tracked state calls for. Mismatches are counted and handed to the top.
// ----------------------------------------------------------------------------
module sync_frame_receiver_xor_check_checker
    import sfr_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              req_valid,
    input  wire logic              req_stall,
    input  wire logic              kind,
    input  wire logic [BYTE_W-1:0] rx_byte,
    input  wire logic [IDX_W-1:0]  read_index,
    input  wire logic              rsp_valid,
    input  wire logic              rsp_stall,
    input  wire logic              frame_done,
    input  wire logic              frame_good,
    input  wire logic [BYTE_W-1:0] read_data,
    input  wire logic              frame_valid,
    output int                     mismatch_count,
    output int                     responses_due
);

    typedef enum logic [1:0] {
        HUNT_FIRST,
        HUNT_SECOND,
        TAKE_PAYLOAD,
        TAKE_CHECKSUM
    } parse_phase_e;

    parse_phase_e      phase;
    int unsigned       write_pos;
    logic [BYTE_W-1:0] frame_xor;
    logic              verified;
    logic [BYTE_W-1:0] payload_copy [PAYLOAD_LEN];
    out_item_t         due_responses [$];

    always @(posedge clk or negedge rst_n)
    begin
        out_item_t want;
        out_item_t got;
        if (!rst_n)
        begin
            phase          = HUNT_FIRST;
            write_pos      = 0;
            frame_xor      = '0;
            verified       = 1'b0;
            mismatch_count = 0;
            due_responses.delete();
            responses_due <= 0;
        end
        else
        begin
            if (rsp_valid && !rsp_stall)
            begin
                got = {frame_done, frame_good, read_data, frame_valid};
                if (due_responses.size() == 0)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("unexpected response: done=%0b good=%0b data=%02h valid=%0b",
                                 got.frame_done, got.frame_good, got.read_data,
                                 got.frame_valid);
                end
                else
                begin
                    want = due_responses.pop_front();
                    if (got !== want)
                    begin
                        mismatch_count++;
                        if (mismatch_count <= 10)
                            $display({"response mismatch: expected done=%0b good=%0b ",
                                      "data=%02h valid=%0b, got done=%0b good=%0b ",
                                      "data=%02h valid=%0b"},
                                     want.frame_done, want.frame_good, want.read_data,
                                     want.frame_valid, got.frame_done, got.frame_good,
                                     got.read_data, got.frame_valid);
                    end
                end
            end

            if (req_valid && !req_stall)
            begin
                want = '0;
                if (kind == KIND_RX)
                begin
                    case (phase)
                        HUNT_FIRST:
                        begin
                            if (rx_byte == SYNC_FIRST)
                                phase = HUNT_SECOND;
                        end
                        HUNT_SECOND:
                        begin
                            if (rx_byte == SYNC_SECOND)
                            begin
                                phase     = TAKE_PAYLOAD;
                                write_pos = 0;
                                frame_xor = '0;
                                verified  = 1'b0;
                            end
                            else if (rx_byte != SYNC_FIRST)
                                phase = HUNT_FIRST;
                        end
                        TAKE_PAYLOAD:
                        begin
                            payload_copy[write_pos] = rx_byte;
                            frame_xor = frame_xor ^ rx_byte;
                            write_pos++;
                            if (write_pos >= PAYLOAD_LEN)
                                phase = TAKE_CHECKSUM;
                        end
                        TAKE_CHECKSUM:
                        begin
                            want.frame_done = 1'b1;
                            if (frame_xor == rx_byte)
                            begin
                                want.frame_good = 1'b1;
                                verified        = 1'b1;
                            end
                            phase = HUNT_FIRST;
                        end
                    endcase
                end
                else if (read_index < PAYLOAD_LEN)
                    want.read_data = payload_copy[read_index];
                want.frame_valid = verified;
                due_responses.push_back(want);
            end
            responses_due <= due_responses.size();
        end
    end

endmodule

/* tb/sync_frame_receiver_xor_check_tb.sv */
// ----------------------------------------------------------------------------
// sync_frame_receiver_xor_check_tb
// Drives serial bytes and readback requests into the sync frame receiver:
// sync hunting noise, one frame whose payload runs across the three idle
// phases with reads mixed in, and reads of stored and out-of-range positions.
// Sender and receiver idle at random, with long response hold-offs that back
// up the requests. The checker beside the block compares every response.
// ----------------------------------------------------------------------------
module sync_frame_receiver_xor_check_tb;
    import sfr_pkg::*;

    localparam int HOLD_CYCLES = 64;
    localparam int QUIET_LIMIT = 2000;
    localparam int MAX_INDEX   = (1 << IDX_W) - 1;
    localparam int FRAME_SLICE = 340;

    logic              clk        = 1'b0;
    logic              rst_n      = 1'b0;
    logic              req_valid  = 1'b0;
    logic              req_stall;
    logic              kind       = KIND_RX;
    logic [BYTE_W-1:0] rx_byte    = '0;
    logic [IDX_W-1:0]  read_index = '0;
    logic              rsp_valid;
    logic              rsp_stall  = 1'b0;
    logic              frame_done;
    logic              frame_good;
    logic [BYTE_W-1:0] read_data;
    logic              frame_valid;

    int mismatch_count;
    int responses_due;
    int send_idle_pct = 10;
    int recv_idle_pct = 49;
    int hold_asked    = 0;
    int hold_served   = 0;
    int stored_len    = 0;
    int frame_pos     = 0;
    int quiet_cycles  = 0;
    bit hunt_armed    = 1'b0;
    logic [BYTE_W-1:0] frame_sum = '0;

    sync_frame_receiver_xor_check uut (
        .clk         (clk),
        .rst_n       (rst_n),
        .req_valid   (req_valid),
        .req_stall   (req_stall),
        .kind        (kind),
        .rx_byte     (rx_byte),
        .read_index  (read_index),
        .rsp_valid   (rsp_valid),
        .rsp_stall   (rsp_stall),
        .frame_done  (frame_done),
        .frame_good  (frame_good),
        .read_data   (read_data),
        .frame_valid (frame_valid)
    );

    sync_frame_receiver_xor_check_checker frame_check (
        .clk            (clk),
        .rst_n          (rst_n),
        .req_valid      (req_valid),
        .req_stall      (req_stall),
        .kind           (kind),
        .rx_byte        (rx_byte),
        .read_index     (read_index),
        .rsp_valid      (rsp_valid),
        .rsp_stall      (rsp_stall),
        .frame_done     (frame_done),
        .frame_good     (frame_good),
        .read_data      (read_data),
        .frame_valid    (frame_valid),
        .mismatch_count (mismatch_count),
        .responses_due  (responses_due)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    task automatic offer_request(input logic k, input logic [BYTE_W-1:0] b,
                                 input logic [IDX_W-1:0] idx);
        while ($urandom_range(99) < send_idle_pct)
        begin
            req_valid <= 1'b0;
            @(posedge clk);
        end
        req_valid  <= 1'b1;
        kind       <= k;
        rx_byte    <= b;
        read_index <= idx;
        @(posedge clk);
        while (req_stall)
            @(posedge clk);
    endtask

    task automatic send_serial(input logic [BYTE_W-1:0] b);
        offer_request(KIND_RX, b, IDX_W'($urandom));
    endtask

    task automatic read_back(input int idx);
        offer_request(KIND_READ, BYTE_W'($urandom), IDX_W'(idx));
    endtask

    // stay within the stored prefix, or go out of range
    task automatic read_random();
        int idx;
        if (stored_len == 0 || $urandom_range(99) < 15)
            idx = $urandom_range(MAX_INDEX, PAYLOAD_LEN);
        else
            idx = $urandom_range(stored_len - 1);
        read_back(idx);
    endtask

    // never complete a sync pair
    task automatic line_noise(input int n);
        logic [BYTE_W-1:0] b;
        repeat (n)
        begin
            if ($urandom_range(3) == 0)
                read_random();
            else
            begin
                b = ($urandom_range(3) == 0) ? SYNC_FIRST : BYTE_W'($urandom);
                if (hunt_armed && b == SYNC_SECOND)
                    b = SYNC_FIRST ^ SYNC_SECOND;
                hunt_armed = (b == SYNC_FIRST);
                send_serial(b);
            end
        end
    endtask

    task automatic frame_open();
        frame_sum = '0;
        frame_pos = 0;
        repeat ($urandom_range(3, 1))
            send_serial(SYNC_FIRST);
        if ($urandom_range(1))
            read_random();
        send_serial(SYNC_SECOND);
    endtask

    task automatic frame_body(input int n);
        logic [BYTE_W-1:0] b;
        repeat (n)
        begin
            case ($urandom_range(7))
                0:       b = SYNC_FIRST;
                1:       b = SYNC_SECOND;
                2:       b = '0;
                3:       b = '1;
                default: b = BYTE_W'($urandom);
            endcase
            send_serial(b);
            frame_sum = frame_sum ^ b;
            frame_pos++;
            if (frame_pos > stored_len)
                stored_len = frame_pos;
            if ($urandom_range(19) == 0)
                read_random();
        end
    endtask

    task automatic frame_close(input bit good);
        send_serial(good ? frame_sum : frame_sum ^ BYTE_W'($urandom_range(255, 1)));
        hunt_armed = 1'b0;
    endtask

    initial
    begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        send_serial(8'h00);
        send_serial(8'hFF);
        send_serial(SYNC_SECOND);
        send_serial(SYNC_FIRST);
        send_serial(8'h00);
        send_serial(SYNC_FIRST);
        read_back(PAYLOAD_LEN);
        send_serial(SYNC_FIRST);
        send_serial(8'hFF);
        read_back(MAX_INDEX);
        read_back(1536);
        send_serial(SYNC_FIRST);
        send_serial(SYNC_FIRST);
        send_serial(8'h12);

        for (int ph = 0; ph < 3; ph++)
        begin
            case (ph)
                0:
                begin
                    send_idle_pct = 10;
                    recv_idle_pct = 49;
                end
                1:
                begin
                    send_idle_pct = 49;
                    recv_idle_pct = 10;
                end
                default:
                begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
            endcase
            if (ph != 1)
                hold_asked++;
            if (ph == 0)
            begin
                line_noise(40);
                frame_open();
            end
            if (ph == 2)
            begin
                frame_body(PAYLOAD_LEN - 2 * FRAME_SLICE);
                frame_close(1'b1);
                read_back(0);
                read_back(PAYLOAD_LEN - 1);
                read_back(PAYLOAD_LEN);
                read_back(MAX_INDEX);
                repeat (100) read_random();
            end
            else
                frame_body(FRAME_SLICE);
        end

        req_valid <= 1'b0;
        do
            @(posedge clk);
        while (responses_due != 0);
        repeat (8) @(posedge clk);
        if (mismatch_count == 0)
            $display("sync_frame_receiver_xor_check regression: pass");
        else
            $display("sync_frame_receiver_xor_check regression: fail");
        $finish;
    end

    // hold off responses when asked, else stall at random
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (hold_served != hold_asked)
            begin
                hold_served = hold_asked;
                rsp_stall <= 1'b1;
                for (int n = 0; n < HOLD_CYCLES; n++)
                    @(posedge clk);
            end
            else
                rsp_stall <= ($urandom_range(99) < recv_idle_pct);
        end
    end

    always @(posedge clk)
    begin
        if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("sync_frame_receiver_xor_check regression: fail");
            $finish;
        end
    end

endmodule

/* sim.f */
src/sfr_pkg.sv
src/sfr_parser.sv
src/sfr_store.sv
src/sfr_outq.sv
src/sync_frame_receiver_xor_check.sv
tb/sync_frame_receiver_xor_check_checker.sv
tb/sync_frame_receiver_xor_check_tb.sv
